[rtl/hand_motion_predictor_assert.svh]
// Assertion macros for the hand motion predictor RTL.
// Used by the top level; needs clk and arst_n in scope where a macro is used.
`ifndef HAND_MOTION_PREDICTOR_ASSERT_SVH
`define HAND_MOTION_PREDICTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, quiet while reset is asserted
`define HMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also covers the reset phase
`define HMP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMP_ASSERT(lbl, prop, msg)
`define HMP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/hmp_pkg.sv]
// Shared widths, constants, types and the Hann weight table for the hand motion predictor.
// No dependencies; imported by every module of the block.
package hmp_pkg;

	// Field widths
	localparam int POS_W   = 24;
	localparam int H_W     = 8;
	localparam int IN_W    = 2 * POS_W + H_W;
	localparam int OUT_W   = 4 * POS_W;

	// Default configuration handed to the top level
	localparam int DEF_VEL_TAPS = 4;
	localparam int DEF_ACC_TAPS = 7;
	localparam int DEF_WARMUP   = 15;

	// Number of pipeline stages behind the input transfer
	localparam int NSTG = 5;

	// Datapath widths
	localparam int VEL_W   = 26;
	localparam int ACC_W   = 26;
	localparam int HANN_W  = 15;
	localparam int HANN_N  = 7;
	localparam int PROD_W  = VEL_W + HANN_W + 1;
	localparam int ASUM_W  = PROD_W + 3;
	localparam int GV_W    = 24;
	localparam int GA_W    = 26;
	localparam int GVN_W   = 40;
	localparam int GAN_W   = 42;
	localparam int MV_W    = GV_W + VEL_W;
	localparam int MA_W    = GA_W + ACC_W;
	localparam int FIN_W   = 54;

	// Rounding shifts
	localparam int ACC_SH  = 16;
	localparam int GAIN_SH = 14;
	localparam int TERM_SH = 18;

	// Gain polynomial coefficients, Q2.30
	localparam logic signed [GVN_W-1:0] GV2 = GVN_W'(-367907);
	localparam logic signed [GVN_W-1:0] GV1 = GVN_W'(221225856);
	localparam logic signed [GVN_W-1:0] GV0 = GVN_W'(994101726);
	localparam logic signed [GAN_W-1:0] GA3 = GAN_W'(-66647);
	localparam logic signed [GAN_W-1:0] GA2 = GAN_W'(21877004);
	localparam logic signed [GAN_W-1:0] GA1 = GAN_W'(292959960);
	localparam logic signed [GAN_W-1:0] GA0 = GAN_W'(893595715);

	// Per-stage load enables, one item in flight
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} hmp_en_t;

	// Velocity and acceleration gains, Q.16
	typedef struct packed {
		logic signed [GV_W-1:0] gv;
		logic signed [GA_W-1:0] ga;
	} hmp_gain_t;

	// Hann acceleration weights, Q0.16; taps past the seventh weigh zero
	function automatic logic [HANN_W-1:0] hann_w(input int k);
		logic [HANN_W-1:0] w;
		case (k)
			0, 6:    w = HANN_W'(2399);
			1, 5:    w = HANN_W'(8192);
			2, 4:    w = HANN_W'(13985);
			3:       w = HANN_W'(16384);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[rtl/hmp_gain.sv]
// Horizon gain unit: evaluates the velocity and acceleration gain polynomials.
// Depends on hmp_pkg; one instance is shared by both axis lanes.
module hmp_gain import hmp_pkg::*; (
	input  logic                  clk,
	input  hmp_en_t               en,
	input  logic signed [H_W-1:0] horizon,
	output hmp_gain_t             gain
);

	logic signed [H_W-1:0]     h_s1;
	logic [H_W-2:0]            hp_s2;
	logic                      hpos_s2;
	logic [2*(H_W-1)-1:0]      h2_s2;
	logic [3*(H_W-1)-1:0]      h3_s3;
	logic                      hpos_s3;
	logic signed [GVN_W-1:0]   gvn_s3;
	logic signed [GAN_W-1:0]   gap_s3;
	logic signed [GV_W-1:0]    gv_s4;
	logic signed [GA_W-1:0]    ga_s4;
	logic signed [GVN_W-1:0]   gvr;
	logic signed [GAN_W-1:0]   gar;

	// Round both polynomials half up to Q.16
	always_comb begin
		gvr = gvn_s3 + GVN_W'(1 << (GAIN_SH - 1));
		gar = GA3 * GAN_W'($signed({1'b0, h3_s3})) + gap_s3 + GAN_W'(1 << (GAIN_SH - 1));
	end

	// Advance the horizon through square, cube and polynomial sums
	always_ff @(posedge clk) begin
		if (en.s1) begin
			h_s1 <= horizon;
		end
		if (en.s2) begin
			hp_s2   <= h_s1[H_W-2:0];
			hpos_s2 <= !h_s1[H_W-1] && (|h_s1[H_W-2:0]);
			h2_s2   <= h_s1[H_W-2:0] * h_s1[H_W-2:0];
		end
		if (en.s3) begin
			h3_s3   <= h2_s2 * hp_s2;
			hpos_s3 <= hpos_s2;
			gvn_s3  <= GV2 * GVN_W'($signed({1'b0, h2_s2}))
				+ GV1 * GVN_W'($signed({1'b0, hp_s2})) + GV0;
			gap_s3  <= GA2 * GAN_W'($signed({1'b0, h2_s2}))
				+ GA1 * GAN_W'($signed({1'b0, hp_s2})) + GA0;
		end
		// Zero gains leave the prediction at the position
		if (en.s4) begin
			gv_s4 <= hpos_s3 ? gvr[GAIN_SH +: GV_W] : '0;
			ga_s4 <= hpos_s3 ? gar[GAIN_SH +: GA_W] : '0;
		end
	end

	assign gain.gv = gv_s4;
	assign gain.ga = ga_s4;

endmodule

[rtl/hmp_lane.sv]
// One axis lane: velocity window, velocity difference, Hann acceleration filter and
// the extrapolation term. Depends on hmp_pkg and on gains from hmp_gain.
module hmp_lane import hmp_pkg::*; #(
	parameter int VEL_TAPS = DEF_VEL_TAPS,
	parameter int ACC_TAPS = DEF_ACC_TAPS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hmp_en_t                 en,
	input  logic signed [POS_W-1:0] pos,
	input  hmp_gain_t               gain,
	output logic signed [POS_W-1:0] pred,
	output logic signed [POS_W-1:0] cur
);

	localparam int V_HIST = VEL_TAPS - 1;
	localparam int A_HIST = ACC_TAPS - 1;
	localparam int HALF   = VEL_TAPS / 2;
	localparam int NPROD  = (ACC_TAPS < HANN_N) ? ACC_TAPS : HANN_N;
	localparam int VSUM_W = POS_W + $clog2(VEL_TAPS) + 1;
	localparam int DIF_W  = VEL_W + 1;

	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// History state
	logic signed [POS_W-1:0]  past_q [V_HIST];
	logic signed [VEL_W-1:0]  lastv_q;
	logic signed [VEL_W-1:0]  acch_q [A_HIST];

	// Pipeline payload
	logic signed [POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic signed [VEL_W-1:0]  vel_s1, vel_s2, vel_s3, vel_s4;
	logic signed [VEL_W-1:0]  diff_s2;
	logic signed [PROD_W-1:0] prod_s3 [NPROD];
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [MV_W-1:0]   mv_s5;
	logic signed [MA_W-1:0]   ma_s5;

	logic signed [POS_W-1:0]  win [VEL_TAPS];
	logic signed [VSUM_W-1:0] vsum;
	logic signed [VEL_W-1:0]  vel_n;
	logic signed [DIF_W-1:0]  dsum;
	logic signed [VEL_W-1:0]  diff_n;
	logic signed [PROD_W-1:0] prod_n [NPROD];
	logic signed [ASUM_W-1:0] asum;
	logic signed [FIN_W-1:0]  fsum;

	// Velocity: newer half minus older half of the window, saturated
	always_comb begin
		for (int i = 0; i < V_HIST; i++) begin
			win[i] = past_q[i];
		end
		win[V_HIST] = pos;
		vsum = '0;
		for (int i = 0; i < VEL_TAPS; i++) begin
			if (i < HALF) begin
				vsum = vsum - VSUM_W'(win[i]);
			end else if (i >= VEL_TAPS - HALF) begin
				vsum = vsum + VSUM_W'(win[i]);
			end
		end
		if ((&vsum[VSUM_W-1:VEL_W-1]) || !(|vsum[VSUM_W-1:VEL_W-1])) begin
			vel_n = vsum[VEL_W-1:0];
		end else begin
			vel_n = vsum[VSUM_W-1] ? VEL_MIN : VEL_MAX;
		end
	end

	// Velocity difference, saturated
	always_comb begin
		dsum = DIF_W'(vel_s1) - DIF_W'(lastv_q);
		if (dsum[DIF_W-1] == dsum[DIF_W-2]) begin
			diff_n = dsum[VEL_W-1:0];
		end else begin
			diff_n = dsum[DIF_W-1] ? VEL_MIN : VEL_MAX;
		end
	end

	// Weighted filter taps: stored differences, then the new one if a weight is left
	for (genvar k = 0; k < NPROD; k++) begin : g_tap
		localparam logic signed [HANN_W:0] WK = {1'b0, hann_w(k)};
		logic signed [VEL_W-1:0] src;
		if (k < A_HIST) begin : g_hist
			assign src = acch_q[k];
		end else begin : g_new
			assign src = diff_s2;
		end
		assign prod_n[k] = PROD_W'(src) * PROD_W'(WK);
	end

	// Filter sum with half-up rounding offset
	always_comb begin
		asum = ASUM_W'(1 << (ACC_SH - 1));
		for (int k = 0; k < NPROD; k++) begin
			asum = asum + ASUM_W'(prod_s3[k]);
		end
	end

	// Position plus rounded gain terms
	always_comb begin
		fsum = (FIN_W'(pos_s5) <<< TERM_SH) + FIN_W'(mv_s5) + FIN_W'(ma_s5)
			+ FIN_W'(1 << (TERM_SH - 1));
		if ((&fsum[FIN_W-1:TERM_SH+POS_W-1]) || !(|fsum[FIN_W-1:TERM_SH+POS_W-1])) begin
			pred = fsum[TERM_SH +: POS_W];
		end else begin
			pred = fsum[FIN_W-1] ? POS_MIN : POS_MAX;
		end
	end

	assign cur = pos_s5;

	// Shift history on the input transfer and as the difference forms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < V_HIST; i++) begin
				past_q[i] <= '0;
			end
			for (int i = 0; i < A_HIST; i++) begin
				acch_q[i] <= '0;
			end
			lastv_q <= '0;
		end else begin
			if (en.s1) begin
				for (int i = 0; i < V_HIST - 1; i++) begin
					past_q[i] <= past_q[i+1];
				end
				past_q[V_HIST-1] <= pos;
			end
			if (en.s2) begin
				lastv_q <= vel_s1;
			end
			if (en.s3) begin
				for (int i = 0; i < A_HIST - 1; i++) begin
					acch_q[i] <= acch_q[i+1];
				end
				acch_q[A_HIST-1] <= diff_s2;
			end
		end
	end

	// Advance the payload one stage per enable
	always_ff @(posedge clk) begin
		if (en.s1) begin
			pos_s1 <= pos;
			vel_s1 <= vel_n;
		end
		if (en.s2) begin
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
			diff_s2 <= diff_n;
		end
		if (en.s3) begin
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
			for (int k = 0; k < NPROD; k++) begin
				prod_s3[k] <= prod_n[k];
			end
		end
		if (en.s4) begin
			pos_s4 <= pos_s3;
			vel_s4 <= vel_s3;
			acc_s4 <= asum[ACC_SH +: ACC_W];
		end
		if (en.s5) begin
			pos_s5 <= pos_s4;
			mv_s5  <= MV_W'(gain.gv) * MV_W'(vel_s4);
			ma_s5  <= MA_W'(gain.ga) * MA_W'(acc_s4);
		end
	end

endmodule

[rtl/hmp_merge.sv]
// Merge stage: joins both lane results, applies warm-up gating and holds the output register.
// Depends on hmp_pkg.
module hmp_merge import hmp_pkg::*; #(
	parameter int WARMUP_SAMPLES = DEF_WARMUP
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic signed [POS_W-1:0] pred_x,
	input  logic signed [POS_W-1:0] pred_y,
	input  logic signed [POS_W-1:0] cur_x,
	input  logic signed [POS_W-1:0] cur_y,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_W-1:0]        m_tdata,
	output logic [0:0]              m_tuser
);

	localparam int CNT_W = $clog2(WARMUP_SAMPLES + 1);

	logic [CNT_W-1:0] warm_cnt_q;
	logic             warm;

	assign warm = (warm_cnt_q == CNT_W'(WARMUP_SAMPLES));

	// Count samples until warm-up completes, then hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (load && !warm) begin
				warm_cnt_q <= warm_cnt_q + CNT_W'(1);
			end
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Capture the merged result; zero it during warm-up
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= warm ? {cur_y, cur_x, pred_y, pred_x} : '0;
			m_tuser <= warm;
		end
	end

endmodule

[rtl/hand_motion_predictor.sv]
// Top level of the hand motion predictor: stage control, shared gain unit, two axis lanes
// and the merge stage. Depends on hmp_pkg, hmp_gain, hmp_lane, hmp_merge and the assert header.
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata: pos_x, pos_y, horizon
// m_*      out        m_tvalid/m_tready  m_tdata: pred_x, pred_y, cur_x, cur_y; m_tuser: valid_res
//
// One sample is in flight at a time; it walks the five lane stages, and a new one is taken
// only once the last lane stage has handed its result to the output register.
// The stages carry the gain polynomials and the two gain multiplies.
// A result waiting in the output register does not block the next input transfer;
// only a second finished result waits in the last lane stage until the register frees.
// Reset clears the history, the warm-up count and all valid flags; no clearing pass.
`include "hand_motion_predictor_assert.svh"

module hand_motion_predictor import hmp_pkg::*; #(
	parameter int VEL_TAPS       = DEF_VEL_TAPS,
	parameter int ACC_TAPS       = DEF_ACC_TAPS,
	parameter int WARMUP_SAMPLES = DEF_WARMUP
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // pos_x [23:0], pos_y [47:24], horizon [55:48]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // pred_x [23:0], pred_y [47:24], cur_x [71:48], cur_y [95:72]
	output logic [0:0]       m_tuser    // valid_res [0]
);

	logic [NSTG-1:0]         stage_v_q;
	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	hmp_en_t                 en;
	hmp_gain_t               gain;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic signed [H_W-1:0]   horizon;
	logic signed [POS_W-1:0] pred_x, pred_y, cur_x, cur_y;

	// Unpack the input transfer
	assign pos_x   = $signed(s_tdata[POS_W-1:0]);
	assign pos_y   = $signed(s_tdata[2*POS_W-1:POS_W]);
	assign horizon = $signed(s_tdata[IN_W-1:2*POS_W]);

	// Take a sample only when none is in flight
	assign s_tready = !(|stage_v_q);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign out_load = stage_v_q[NSTG-1] && out_free;

	assign en.s1 = accept;
	assign en.s2 = stage_v_q[0];
	assign en.s3 = stage_v_q[1];
	assign en.s4 = stage_v_q[2];
	assign en.s5 = stage_v_q[3];

	// Advance the stage flags; hold the last one until the output register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q <= '0;
		end else begin
			stage_v_q[0] <= accept;
			for (int i = 1; i < NSTG - 1; i++) begin
				stage_v_q[i] <= stage_v_q[i-1];
			end
			stage_v_q[NSTG-1] <= stage_v_q[NSTG-2] || (stage_v_q[NSTG-1] && !out_free);
		end
	end

	hmp_gain u_gain (
		.clk     (clk),
		.en      (en),
		.horizon (horizon),
		.gain    (gain)
	);

	hmp_lane #(
		.VEL_TAPS (VEL_TAPS),
		.ACC_TAPS (ACC_TAPS)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.pos    (pos_x),
		.gain   (gain),
		.pred   (pred_x),
		.cur    (cur_x)
	);

	hmp_lane #(
		.VEL_TAPS (VEL_TAPS),
		.ACC_TAPS (ACC_TAPS)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.pos    (pos_y),
		.gain   (gain),
		.pred   (pred_y),
		.cur    (cur_y)
	);

	hmp_merge #(
		.WARMUP_SAMPLES (WARMUP_SAMPLES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.pred_x   (pred_x),
		.pred_y   (pred_y),
		.cur_x    (cur_x),
		.cur_y    (cur_y),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Pipeline control checks
	`HMP_ASSERT(a_one_in_flight, $onehot0(stage_v_q), "more than one sample in flight")
	`HMP_ASSERT(a_enter_alone, accept |=> (stage_v_q == NSTG'(1)), "sample did not enter alone")
	`HMP_ASSERT(a_hold_last, stage_v_q[NSTG-1] && !out_free |=> stage_v_q[NSTG-1], "result dropped")
	`HMP_ASSERT(a_load_shows, out_load |=> m_tvalid, "loaded result not presented")
	`HMP_ASSERT_RST(a_rst_quiet, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule
